FILE: rtl/saf_pkg.sv
`timescale 1ns / 1ps

package saf_pkg;

  localparam int unsigned IGNORE_DEPTH_DEF = 128;
  localparam int unsigned FRAME_CAP        = 16;
  localparam int unsigned ADDR_W           = 64;
  localparam int unsigned HALF_W           = 8;
  localparam int unsigned LIMIT_W          = 5;
  localparam int unsigned COUNT_W          = 32;

  localparam logic [HALF_W-1:0]  HALF_WIDTH_RST  = 8'd15;
  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = 5'd10;

  // operation codes
  localparam logic [1:0] OP_ADD          = 2'd0;
  localparam logic [1:0] OP_CLEAR_TABLE  = 2'd1;
  localparam logic [1:0] OP_FRAME        = 2'd2;
  localparam logic [1:0] OP_CLEAR_COUNTS = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_START = 2'd0;
  localparam logic [1:0] REG_IMAGE_END   = 2'd1;
  localparam logic [1:0] REG_HALF_WIDTH  = 2'd2;
  localparam logic [1:0] REG_FRAME_LIMIT = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] address;
    logic              last_frame;
  } saf_in_t;

  typedef struct packed {
    logic               status;
    logic               sample_done;
    logic               sample_in_image;
    logic [COUNT_W-1:0] image_count;
    logic [COUNT_W-1:0] other_count;
    logic [7:0]         ignored_count;
  } saf_out_t;

  typedef struct packed {
    logic busy;
    logic finish;
    logic matched;
  } saf_scan_status_t;

endpackage

FILE: rtl/saf_ram.sv
`timescale 1ns / 1ps

module saf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/saf_window_cmp.sv
`timescale 1ns / 1ps

module saf_window_cmp (
  input  logic [saf_pkg::ADDR_W-1:0] address,
  input  logic [saf_pkg::ADDR_W-1:0] center,
  input  logic [saf_pkg::HALF_W-1:0] half_width,
  output logic                       in_window
);

  logic [saf_pkg::ADDR_W-1:0] delta;

  // a clamped window is the same as distance <= half width
  always_comb begin
    if (address >= center) begin
      delta = address - center;
    end else begin
      delta = center - address;
    end
    in_window = (delta[saf_pkg::ADDR_W-1:saf_pkg::HALF_W] == '0) &&
                (delta[saf_pkg::HALF_W-1:0] <= half_width);
  end

endmodule

FILE: rtl/saf_scan_ctrl.sv
`timescale 1ns / 1ps

module saf_scan_ctrl #(
  parameter int unsigned IGNORE_DEPTH = saf_pkg::IGNORE_DEPTH_DEF,
  localparam int unsigned CW = $clog2(IGNORE_DEPTH + 1),
  localparam int unsigned AW = (IGNORE_DEPTH > 1) ? $clog2(IGNORE_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      launch,
  input  logic [CW-1:0]             entries,
  input  logic                      match,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  output saf_pkg::saf_scan_status_t scan_st
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic          pend, pend_next;
  logic          issue;
  logic          hit_w;
  logic          drained;

  always_comb begin
    issue      = (state == S_WALK) && (idx < entries);
    hit_w      = (state == S_WALK) && pend && match;
    drained    = (state == S_WALK) && !pend && !issue;
    rd_en      = issue;
    rd_addr    = idx[AW-1:0];
    state_next = state;
    idx_next   = idx;
    pend_next  = pend;
    case (state)
      S_IDLE: begin
        if (launch) begin
          state_next = S_WALK;
          idx_next   = '0;
          pend_next  = 1'b0;
        end
      end
      S_WALK: begin
        pend_next = issue;
        if (issue) begin
          idx_next = idx + CW'(1);
        end
        if (hit_w || drained) begin
          state_next = S_IDLE;
          pend_next  = 1'b0;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    scan_st.busy    = (state != S_IDLE);
    scan_st.finish  = hit_w || drained;
    scan_st.matched = hit_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      pend  <= pend_next;
    end
  end

endmodule

FILE: rtl/sample_address_filter_top.sv
`timescale 1ns / 1ps
// channel  | ports                              | transfer
// command  | start, busy, cmd                   | start high and busy low at a rising edge
// result   | done, result                       | done high for one cycle, always taken
// config   | cfg_write, cfg_index, cfg_data     | cfg_write high at a rising edge
//
// add, clear and counter ops return their result in the cycle after they are accepted.
// a frame that needs the ignore table walk holds busy high while one table entry
// a cycle is read and checked by the one window comparator; a match ends the walk
// early. other frames return their result in the cycle after they are accepted.
// rst is synchronous; it clears counters, entry count and sample state and
// restores config defaults. the receiver cannot stall; busy holds off new commands.

module sample_address_filter_top #(
  parameter int unsigned IGNORE_DEPTH = saf_pkg::IGNORE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  saf_pkg::saf_in_t           cmd,
  output logic                       done,
  output saf_pkg::saf_out_t          result,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [saf_pkg::ADDR_W-1:0] cfg_data
);

  localparam int unsigned CW = $clog2(IGNORE_DEPTH + 1);
  localparam int unsigned AW = (IGNORE_DEPTH > 1) ? $clog2(IGNORE_DEPTH) : 1;

  logic [saf_pkg::ADDR_W-1:0]  image_start;
  logic [saf_pkg::ADDR_W-1:0]  image_end;
  logic [saf_pkg::HALF_W-1:0]  half_width;
  logic [saf_pkg::LIMIT_W-1:0] frame_limit;

  logic [CW-1:0]                entries, entries_next;
  logic [saf_pkg::COUNT_W-1:0]  image_cnt, image_cnt_next;
  logic [saf_pkg::COUNT_W-1:0]  other_cnt, other_cnt_next;
  logic                         hit, hit_next;
  logic [saf_pkg::LIMIT_W-1:0]  frame_idx, frame_idx_next;
  saf_pkg::saf_out_t            result_next;
  logic                         done_next;

  logic [saf_pkg::ADDR_W-1:0] item_addr;
  logic                       item_last;

  logic                        accept;
  logic [saf_pkg::LIMIT_W-1:0] eff_limit;
  logic                        examined_now;
  logic                        cand;
  logic                        launch;
  logic                        ram_we;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [saf_pkg::ADDR_W-1:0]  rd_data;
  logic                        match;
  saf_pkg::saf_scan_status_t   scan_st;

  logic frame_commit;
  logic frame_hit;
  logic frame_examined;
  logic commit_last;
  logic hit_now;
  logic add_refused;

  assign busy   = scan_st.busy;
  assign accept = start && !busy;

  always_comb begin
    if (frame_limit == '0) begin
      eff_limit = saf_pkg::LIMIT_W'(1);
    end else if (frame_limit > saf_pkg::LIMIT_W'(saf_pkg::FRAME_CAP)) begin
      eff_limit = saf_pkg::LIMIT_W'(saf_pkg::FRAME_CAP);
    end else begin
      eff_limit = frame_limit;
    end
    examined_now = frame_idx < eff_limit;
    cand = examined_now && !hit && (cmd.address >= image_start) &&
           (cmd.address <= image_end);
  end

  saf_ram #(
    .WIDTH(saf_pkg::ADDR_W),
    .DEPTH(IGNORE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(entries[AW-1:0]),
    .wdata(cmd.address),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  saf_window_cmp u_cmp (
    .address   (item_addr),
    .center    (rd_data),
    .half_width(half_width),
    .in_window (match)
  );

  saf_scan_ctrl #(
    .IGNORE_DEPTH(IGNORE_DEPTH)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .launch (launch),
    .entries(entries),
    .match  (match),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .scan_st(scan_st)
  );

  always_comb begin
    entries_next   = entries;
    image_cnt_next = image_cnt;
    other_cnt_next = other_cnt;
    hit_next       = hit;
    frame_idx_next = frame_idx;
    done_next      = 1'b0;
    ram_we         = 1'b0;
    launch         = 1'b0;
    frame_commit   = 1'b0;
    frame_hit      = 1'b0;
    frame_examined = 1'b0;
    commit_last    = 1'b0;
    add_refused    = 1'b0;
    hit_now        = 1'b0;
    result_next    = '0;

    if (accept) begin
      case (cmd.op)
        saf_pkg::OP_ADD: begin
          done_next = 1'b1;
          if (entries < CW'(IGNORE_DEPTH)) begin
            ram_we       = 1'b1;
            entries_next = entries + CW'(1);
          end else begin
            add_refused = 1'b1;
          end
        end
        saf_pkg::OP_CLEAR_TABLE: begin
          done_next    = 1'b1;
          entries_next = '0;
        end
        saf_pkg::OP_FRAME: begin
          // only a candidate hit with a non-empty table needs the walk
          if (cand && (entries != '0)) begin
            launch = 1'b1;
          end else begin
            frame_commit   = 1'b1;
            frame_hit      = cand;
            frame_examined = examined_now;
            commit_last    = cmd.last_frame;
          end
        end
        saf_pkg::OP_CLEAR_COUNTS: begin
          done_next      = 1'b1;
          image_cnt_next = '0;
          other_cnt_next = '0;
        end
        default: begin
          done_next = 1'b1;
        end
      endcase
    end else if (scan_st.finish) begin
      frame_commit   = 1'b1;
      frame_hit      = !scan_st.matched;
      frame_examined = 1'b1;
      commit_last    = item_last;
    end

    if (frame_commit) begin
      done_next = 1'b1;
      hit_now   = hit || frame_hit;
      hit_next  = hit_now;
      if (frame_examined) begin
        frame_idx_next = frame_idx + saf_pkg::LIMIT_W'(1);
      end
      if (commit_last) begin
        result_next.sample_done     = 1'b1;
        result_next.sample_in_image = hit_now;
        if (hit_now) begin
          if (image_cnt != '1) begin
            image_cnt_next = image_cnt + saf_pkg::COUNT_W'(1);
          end
        end else begin
          if (other_cnt != '1) begin
            other_cnt_next = other_cnt + saf_pkg::COUNT_W'(1);
          end
        end
        hit_next       = 1'b0;
        frame_idx_next = '0;
      end
    end

    result_next.status        = add_refused;
    result_next.image_count   = image_cnt_next;
    result_next.other_count   = other_cnt_next;
    result_next.ignored_count = 8'(entries_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_start <= '0;
      image_end   <= '0;
      half_width  <= saf_pkg::HALF_WIDTH_RST;
      frame_limit <= saf_pkg::FRAME_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        saf_pkg::REG_IMAGE_START: image_start <= cfg_data;
        saf_pkg::REG_IMAGE_END:   image_end   <= cfg_data;
        saf_pkg::REG_HALF_WIDTH:  half_width  <= cfg_data[saf_pkg::HALF_W-1:0];
        saf_pkg::REG_FRAME_LIMIT: frame_limit <= cfg_data[saf_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries   <= '0;
      image_cnt <= '0;
      other_cnt <= '0;
      hit       <= 1'b0;
      frame_idx <= '0;
      done      <= 1'b0;
    end else begin
      entries   <= entries_next;
      image_cnt <= image_cnt_next;
      other_cnt <= other_cnt_next;
      hit       <= hit_next;
      frame_idx <= frame_idx_next;
      done      <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result <= result_next;
    if (accept) begin
      item_addr <= cmd.address;
      item_last <= cmd.last_frame;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe during table walk");

  a_entries_bound: assert property (@(posedge clk) disable iff (rst)
    entries <= CW'(IGNORE_DEPTH))
    else $error("ignore table count above depth");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !scan_st.busy)
    else $error("table write while walking");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept || scan_st.finish))
    else $error("result without a command or walk end");

  a_in_image_closed: assert property (@(posedge clk) disable iff (rst)
    (done && !result.sample_done) |-> !result.sample_in_image)
    else $error("in-image flag without closed sample");
`endif

endmodule
